>>> sv/tmq_pkg.sv
package tmq_pkg;

  typedef logic [16:0] evt_time_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_EVENT = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_NEXT = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> sv/timed_event_min_queue_top.sv
// add, or next on an empty table: the status goes to the pending register on acceptance
//   and then to the output register once it is free; next: the best-so-far beat walks
//   the cell row one cell per cycle, then the later entries all close up together
// one request at a time: a new input beat is taken once the previous result is
//   in the output register, so no new request is taken while one is in flight
// rst_ni clears the entry count and all handshake state; entry storage is not reset
module timed_event_min_queue_top #(
  parameter int DEPTH = 16,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [4:0] hours_i,
  input  logic [5:0] minutes_i,
  input  logic [5:0] seconds_i,
  input  logic [7:0] client_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [4:0] out_hours_o,
  output logic [5:0] out_minutes_o,
  output logic [5:0] out_seconds_o,
  output logic [7:0] out_client_o
);
  import tmq_pkg::*;

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q;
  status_e        pend_status_q;
  evt_time_t      pend_time_q;
  logic [7:0]     pend_client_q;
  logic           out_valid_q;
  status_e        out_status_q;
  evt_time_t      out_time_q;
  logic [7:0]     out_client_q;

  logic           accept;
  logic           is_full;
  logic           is_empty;
  logic           start;
  logic           out_load;
  cell_ctrl_t     ctrl;
  evt_time_t      in_time;

  logic           tok_chain     [DEPTH+1];
  evt_time_t      btime_chain   [DEPTH+1];
  logic [7:0]     bclient_chain [DEPTH+1];
  logic [IW-1:0]  bidx_chain    [DEPTH+1];
  evt_time_t      ent_time      [DEPTH];
  logic [7:0]     ent_client    [DEPTH];

  assign in_time    = {hours_i, minutes_i, seconds_i};
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign start      = accept && (req_type_i == REQ_NEXT) && !is_empty;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctrl.wr    = accept && (req_type_i == REQ_ADD) && !is_full;
    ctrl.shift = (state_q == S_SCAN) && tok_chain[DEPTH];
  end

  assign tok_chain[0]     = start;
  assign btime_chain[0]   = '0;
  assign bclient_chain[0] = '0;
  assign bidx_chain[0]    = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    evt_time_t  nb_time;
    logic [7:0] nb_client;
    if (k < DEPTH - 1) begin : g_nb
      assign nb_time   = ent_time[k+1];
      assign nb_client = ent_client[k+1];
    end else begin : g_last
      assign nb_time   = '0;
      assign nb_client = '0;
    end

    tmq_cell #(
      .DEPTH(DEPTH),
      .IDX  (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .rm_idx_i   (bidx_chain[DEPTH]),
      .in_time_i  (in_time),
      .in_client_i(client_id_i),
      .nb_time_i  (nb_time),
      .nb_client_i(nb_client),
      .tok_i      (tok_chain[k]),
      .btime_i    (btime_chain[k]),
      .bclient_i  (bclient_chain[k]),
      .bidx_i     (bidx_chain[k]),
      .time_o     (ent_time[k]),
      .client_o   (ent_client[k]),
      .tok_o      (tok_chain[k+1]),
      .btime_o    (btime_chain[k+1]),
      .bclient_o  (bclient_chain[k+1]),
      .bidx_o     (bidx_chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = start ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (ctrl.shift) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl.wr) begin
      count_q <= count_q + CW'(1);
    end else if (ctrl.shift) begin
      count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_time_q   <= '0;
      pend_client_q <= '0;
      if (req_type_i == REQ_ADD) begin
        pend_status_q <= is_full ? ST_FULL : ST_ADDED;
      end else begin
        pend_status_q <= is_empty ? ST_EMPTY : ST_EVENT;
      end
    end else if (ctrl.shift) begin
      pend_time_q   <= btime_chain[DEPTH];
      pend_client_q <= bclient_chain[DEPTH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= pend_status_q;
      out_time_q   <= pend_time_q;
      out_client_q <= pend_client_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_hours_o   = out_time_q[16:12];
  assign out_minutes_o = out_time_q[11:6];
  assign out_seconds_o = out_time_q[5:0];
  assign out_client_o  = out_client_q;

endmodule

>>> sv/tmq_cell.sv
module tmq_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1),
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmq_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]       count_i,
  input  logic [IW-1:0]       rm_idx_i,
  input  tmq_pkg::evt_time_t  in_time_i,
  input  logic [7:0]          in_client_i,
  input  tmq_pkg::evt_time_t  nb_time_i,
  input  logic [7:0]          nb_client_i,
  input  logic                tok_i,
  input  tmq_pkg::evt_time_t  btime_i,
  input  logic [7:0]          bclient_i,
  input  logic [IW-1:0]       bidx_i,
  output tmq_pkg::evt_time_t  time_o,
  output logic [7:0]          client_o,
  output logic                tok_o,
  output tmq_pkg::evt_time_t  btime_o,
  output logic [7:0]          bclient_o,
  output logic [IW-1:0]       bidx_o
);
  import tmq_pkg::*;

  evt_time_t      time_q;
  logic [7:0]     client_q;
  logic           tok_q;
  evt_time_t      btime_q;
  logic [7:0]     bclient_q;
  logic [IW-1:0]  bidx_q;
  logic           live;
  logic           take_own;
  logic           do_wr;
  logic           do_shift;

  always_comb begin
    live     = CW'(IDX) < count_i;
    // strict less keeps the earlier inserted entry on a tie
    take_own = live && ((IDX == 0) || (time_q < btime_i));
    do_wr    = ctrl_i.wr && (CW'(IDX) == count_i);
    do_shift = ctrl_i.shift && (IW'(IDX) >= rm_idx_i) && (CW'(IDX + 1) < count_i);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      time_q   <= in_time_i;
      client_q <= in_client_i;
    end else if (do_shift) begin
      time_q   <= nb_time_i;
      client_q <= nb_client_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      if (take_own) begin
        btime_q   <= time_q;
        bclient_q <= client_q;
        bidx_q    <= IW'(IDX);
      end else begin
        btime_q   <= btime_i;
        bclient_q <= bclient_i;
        bidx_q    <= bidx_i;
      end
    end
  end

  assign time_o    = time_q;
  assign client_o  = client_q;
  assign tok_o     = tok_q;
  assign btime_o   = btime_q;
  assign bclient_o = bclient_q;
  assign bidx_o    = bidx_q;

endmodule

>>> sv/tmq_checker.sv
module tmq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [4:0] out_hours_o,
  input logic [5:0] out_minutes_o,
  input logic [5:0] out_seconds_o,
  input logic [7:0] out_client_o
);
  import tmq_pkg::*;

  // only a returned event carries a time and a client
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_EVENT)) |->
      (out_hours_o == '0 && out_minutes_o == '0 && out_seconds_o == '0 &&
       out_client_o == '0))
    else $error("result fields not zero for a non-event status");

  // one request in flight: no input beat right after another
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input beat accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(status_o) && $stable(out_hours_o) && $stable(out_minutes_o) &&
       $stable(out_seconds_o) && $stable(out_client_o)))
    else $error("result payload changed while stalled");

endmodule

bind timed_event_min_queue_top tmq_checker u_tmq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .out_hours_o  (out_hours_o),
  .out_minutes_o(out_minutes_o),
  .out_seconds_o(out_seconds_o),
  .out_client_o (out_client_o)
);

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmq_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_e    status;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] client;
  } outcome_t;

  typedef struct packed {
    evt_time_t  stamp;
    logic [7:0] client;
  } event_entry_t;

  typedef struct {
    req_e       req;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] client;
    bit         typed;
    outcome_t   want;
  } stim_row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       req_type_i = REQ_ADD;
  logic [4:0] hours_i = '0;
  logic [5:0] minutes_i = '0;
  logic [5:0] seconds_i = '0;
  logic [7:0] client_id_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [4:0] out_hours_o;
  logic [5:0] out_minutes_o;
  logic [5:0] out_seconds_o;
  logic [7:0] out_client_o;

  // predictor state: the event table in insertion order
  event_entry_t event_table[$];
  outcome_t     pending_results[$];
  stim_row_t    stim_rows[$];

  int mismatches = 0;
  int n_added = 0;
  int n_returned = 0;
  int n_empty = 0;
  int n_full = 0;
  int burst_left = 0;
  int cycle_count = 0;

  timed_event_min_queue_top #(.DEPTH(DEPTH)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .hours_i      (hours_i),
    .minutes_i    (minutes_i),
    .seconds_i    (seconds_i),
    .client_id_i  (client_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_hours_o  (out_hours_o),
    .out_minutes_o(out_minutes_o),
    .out_seconds_o(out_seconds_o),
    .out_client_o (out_client_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_row(stim_row_t row);
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  function automatic outcome_t serve_request(req_e req, logic [4:0] hh, logic [5:0] mm,
                                             logic [5:0] ss, logic [7:0] cl);
    outcome_t r;
    int best;
    r = '0;
    if (req == REQ_ADD) begin
      if (event_table.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        event_table.insert(event_table.size(), '{stamp: {hh, mm, ss}, client: cl});
        r.status = ST_ADDED;
      end
    end else if (event_table.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // strict compare keeps the earliest inserted entry on a tie
      best = 0;
      for (int k = 1; k < event_table.size(); k++) begin
        if (event_table[k].stamp < event_table[best].stamp) best = k;
      end
      r.status  = ST_EVENT;
      r.hours   = event_table[best].stamp[16:12];
      r.minutes = event_table[best].stamp[11:6];
      r.seconds = event_table[best].stamp[5:0];
      r.client  = event_table[best].client;
      event_table.delete(best);
    end
    return r;
  endfunction

  task automatic send_request(input req_e req, input logic [4:0] hh, input logic [5:0] mm,
                              input logic [5:0] ss, input logic [7:0] cl, input bit typed,
                              input outcome_t want, input bit drain);
    int gap;
    outcome_t model;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain && pending_results.size() != 0) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    hours_i     <= hh;
    minutes_i   <= mm;
    seconds_i   <= ss;
    client_id_i <= cl;
    do @(posedge clk_i); while (!in_ready_o);
    model = serve_request(req, hh, mm, ss, cl);
    pending_results.insert(pending_results.size(), typed ? want : model);
  endtask

  // receiver stall pattern, switched at random between open, random, periodic and long-stall modes
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_tick = 0;
  int       rx_stall = 0;
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_ready_i <= 1'b1;
      RX_RANDOM:   out_ready_i <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: out_ready_i <= (rx_tick % 8 < 5);
      default: begin
        if (rx_stall != 0) begin
          rx_stall--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(5, 20);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_e'(status_o), out_hours_o, out_minutes_o, out_seconds_o, out_client_o};
      case (got.status)
        ST_ADDED: n_added++;
        ST_EVENT: n_returned++;
        ST_EMPTY: n_empty++;
        default:  n_full++;
      endcase
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: status %0d %0d:%0d:%0d client %0d", got.status,
                   got.hours, got.minutes, got.seconds, got.client);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.hours !== want.hours ||
            got.minutes !== want.minutes || got.seconds !== want.seconds ||
            got.client !== want.client) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected status %0d %0d:%0d:%0d client %0d, ",
                      "got status %0d %0d:%0d:%0d client %0d"},
                     want.status, want.hours, want.minutes, want.seconds, want.client,
                     got.status, got.hours, got.minutes, got.seconds, got.client);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("timed_event_min_queue_top regression: fail");
      $finish;
    end
  end

  initial begin
    outcome_t   none;
    int         add_pct;
    req_e       req;
    logic [4:0] hh;
    logic [5:0] mm;
    logic [5:0] ss;

    none = '0;
    add_row('{REQ_NEXT, 5'd0, 6'd0, 6'd0, 8'd0, 1'b1, '{status: ST_EMPTY, default: '0}});
    add_row('{REQ_ADD, 5'd31, 6'd63, 6'd63, 8'd255, 1'b1, '{status: ST_ADDED, default: '0}});
    add_row('{REQ_ADD, 5'd0, 6'd0, 6'd0, 8'd0, 1'b1, '{status: ST_ADDED, default: '0}});
    add_row('{REQ_NEXT, 5'd0, 6'd0, 6'd0, 8'd0, 1'b1, '{status: ST_EVENT, default: '0}});
    add_row('{REQ_NEXT, 5'd31, 6'd63, 6'd63, 8'd255, 1'b1,
              '{ST_EVENT, 5'd31, 6'd63, 6'd63, 8'd255}});
    add_row('{REQ_NEXT, 5'd0, 6'd0, 6'd0, 8'd0, 1'b1, '{status: ST_EMPTY, default: '0}});
    // fill the table with many tied times, then one add too many
    for (int i = 0; i < DEPTH; i++)
      add_row('{REQ_ADD, 5'(12 + i % 2), 6'd30, 6'(i / 4), 8'(i), 1'b1,
                '{status: ST_ADDED, default: '0}});
    add_row('{REQ_ADD, 5'd0, 6'd0, 6'd0, 8'd77, 1'b1, '{status: ST_FULL, default: '0}});
    add_row('{REQ_NEXT, 5'd0, 6'd0, 6'd0, 8'd0, 1'b0, none});
    add_row('{REQ_NEXT, 5'd0, 6'd0, 6'd0, 8'd0, 1'b0, none});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i])
      send_request(stim_rows[i].req, stim_rows[i].hours, stim_rows[i].minutes,
                   stim_rows[i].seconds, stim_rows[i].client, stim_rows[i].typed,
                   stim_rows[i].want, 1'b0);

    add_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // phases lean toward filling or draining the table
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0:       add_pct = 10;
          1:       add_pct = 40;
          2:       add_pct = 60;
          default: add_pct = 90;
        endcase
      end
      req = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_NEXT;
      case ($urandom_range(0, 3))
        0: begin
          hh = 5'($urandom);
          mm = 6'($urandom);
          ss = 6'($urandom);
        end
        1: begin
          // narrow range so ties are common
          hh = 5'($urandom_range(0, 1));
          mm = 6'($urandom_range(0, 1));
          ss = 6'($urandom_range(0, 1));
        end
        default: begin
          hh = 5'($urandom_range(0, 23));
          mm = 6'($urandom_range(0, 59));
          ss = 6'($urandom_range(0, 59));
        end
      endcase
      send_request(req, hh, mm, ss, 8'($urandom), 1'b0, none,
                   n == 0 || n == RANDOM_ITEMS / 2);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 5) @(posedge clk_i);

    $display("%0d requests sent: %0d added, %0d events returned, %0d on empty, %0d on full",
             stim_rows.size() + RANDOM_ITEMS, n_added, n_returned, n_empty, n_full);
    $display("%0d mismatches, %0d results still expected", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("timed_event_min_queue_top regression: pass");
    end else begin
      $display("timed_event_min_queue_top regression: fail");
    end
    $finish;
  end

endmodule

>>> timed_event_min_queue_top.f
sv/tmq_pkg.sv
sv/tmq_cell.sv
sv/timed_event_min_queue_top.sv
sv/tmq_checker.sv
tb/sv/tb.sv
